// ----- src/srt_pkg.sv -----
package srt_pkg;

    localparam int MAX_CELLS_DEF = 64;
    localparam int COLS_W        = 7;
    localparam int BYTE_W        = 8;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int PC_W          = 5;

    localparam logic [BYTE_W-1:0] PAD_BYTE    = 8'h2D;
    localparam logic [COLS_W-1:0] COLUMNS_RST = 7'd4;
    localparam logic              MODE_RST    = 1'b0;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_MODE    = 1'b1;

    typedef logic [PC_W-1:0] upc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SIZE_INIT,
        OP_SIZE_STEP,
        OP_RING_INIT,
        OP_SPIRAL_RD,
        OP_WR_DOWN,
        OP_WR_LEFT,
        OP_WR_UP,
        OP_WR_RIGHT,
        OP_SHRINK,
        OP_RO_INIT,
        OP_RO_RD,
        OP_RO_WR,
        OP_FINISH
    } uop_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_LAST_IN,
        C_SIZE_MORE,
        C_RING,
        C_MORE_DOWN,
        C_MORE_LEFT,
        C_MORE_UP,
        C_MORE_RIGHT,
        C_ROW_LEFT,
        C_ROW_MORE,
        C_COL_LEFT,
        C_COL_MORE,
        C_DECRYPT,
        C_RO_MORE
    } ucond_t;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   tgt_t;
        upc_t   tgt_f;
    } uword_t;

    typedef struct packed {
        logic hold;
        logic last_in;
        logic size_more;
        logic ring;
        logic more_down;
        logic more_left;
        logic more_up;
        logic more_right;
        logic row_left;
        logic row_more;
        logic col_left;
        logic col_more;
        logic decrypt;
        logic ro_more;
    } uflags_t;

endpackage

// ----- src/srt_useq.sv -----
module srt_useq import srt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  uflags_t flags_i,
    output uword_t  uword_o
);

    localparam upc_t ST_IDLE      = 5'd0;
    localparam upc_t ST_SIZE_INIT = 5'd1;
    localparam upc_t ST_SIZE      = 5'd2;
    localparam upc_t ST_RING_INIT = 5'd3;
    localparam upc_t ST_RING_CHK  = 5'd4;
    localparam upc_t ST_DOWN_RD   = 5'd5;
    localparam upc_t ST_DOWN_WR   = 5'd6;
    localparam upc_t ST_LEFT_RD   = 5'd7;
    localparam upc_t ST_LEFT_WR   = 5'd8;
    localparam upc_t ST_UP_RD     = 5'd9;
    localparam upc_t ST_UP_WR     = 5'd10;
    localparam upc_t ST_RIGHT_RD  = 5'd11;
    localparam upc_t ST_RIGHT_WR  = 5'd12;
    localparam upc_t ST_SHRINK    = 5'd13;
    localparam upc_t ST_ROW_CHK   = 5'd14;
    localparam upc_t ST_ROW_RD    = 5'd15;
    localparam upc_t ST_ROW_WR    = 5'd16;
    localparam upc_t ST_COL_CHK   = 5'd17;
    localparam upc_t ST_COL_RD    = 5'd18;
    localparam upc_t ST_COL_WR    = 5'd19;
    localparam upc_t ST_MODE_CHK  = 5'd20;
    localparam upc_t ST_RO_INIT   = 5'd21;
    localparam upc_t ST_RO_RD     = 5'd22;
    localparam upc_t ST_RO_WR     = 5'd23;
    localparam upc_t ST_FINISH    = 5'd24;

    function automatic uword_t ucode_rom(input upc_t pc);
        uword_t w;
        case (pc)
            ST_IDLE:      w = '{OP_LOAD,      C_LAST_IN,    ST_SIZE_INIT, ST_IDLE};
            ST_SIZE_INIT: w = '{OP_SIZE_INIT, C_ALWAYS,     ST_SIZE,      ST_SIZE};
            ST_SIZE:      w = '{OP_SIZE_STEP, C_SIZE_MORE,  ST_SIZE,      ST_RING_INIT};
            ST_RING_INIT: w = '{OP_RING_INIT, C_ALWAYS,     ST_RING_CHK,  ST_RING_CHK};
            ST_RING_CHK:  w = '{OP_NOP,       C_RING,       ST_DOWN_RD,   ST_ROW_CHK};
            ST_DOWN_RD:   w = '{OP_SPIRAL_RD, C_ALWAYS,     ST_DOWN_WR,   ST_DOWN_WR};
            ST_DOWN_WR:   w = '{OP_WR_DOWN,   C_MORE_DOWN,  ST_DOWN_RD,   ST_LEFT_RD};
            ST_LEFT_RD:   w = '{OP_SPIRAL_RD, C_ALWAYS,     ST_LEFT_WR,   ST_LEFT_WR};
            ST_LEFT_WR:   w = '{OP_WR_LEFT,   C_MORE_LEFT,  ST_LEFT_RD,   ST_UP_RD};
            ST_UP_RD:     w = '{OP_SPIRAL_RD, C_ALWAYS,     ST_UP_WR,     ST_UP_WR};
            ST_UP_WR:     w = '{OP_WR_UP,     C_MORE_UP,    ST_UP_RD,     ST_RIGHT_RD};
            ST_RIGHT_RD:  w = '{OP_SPIRAL_RD, C_ALWAYS,     ST_RIGHT_WR,  ST_RIGHT_WR};
            ST_RIGHT_WR:  w = '{OP_WR_RIGHT,  C_MORE_RIGHT, ST_RIGHT_RD,  ST_SHRINK};
            ST_SHRINK:    w = '{OP_SHRINK,    C_ALWAYS,     ST_RING_CHK,  ST_RING_CHK};
            ST_ROW_CHK:   w = '{OP_NOP,       C_ROW_LEFT,   ST_ROW_RD,    ST_COL_CHK};
            ST_ROW_RD:    w = '{OP_SPIRAL_RD, C_ALWAYS,     ST_ROW_WR,    ST_ROW_WR};
            ST_ROW_WR:    w = '{OP_WR_LEFT,   C_ROW_MORE,   ST_ROW_RD,    ST_MODE_CHK};
            ST_COL_CHK:   w = '{OP_NOP,       C_COL_LEFT,   ST_COL_RD,    ST_MODE_CHK};
            ST_COL_RD:    w = '{OP_SPIRAL_RD, C_ALWAYS,     ST_COL_WR,    ST_COL_WR};
            ST_COL_WR:    w = '{OP_WR_DOWN,   C_COL_MORE,   ST_COL_RD,    ST_MODE_CHK};
            ST_MODE_CHK:  w = '{OP_NOP,       C_DECRYPT,    ST_RO_INIT,   ST_FINISH};
            ST_RO_INIT:   w = '{OP_RO_INIT,   C_ALWAYS,     ST_RO_RD,     ST_RO_RD};
            ST_RO_RD:     w = '{OP_RO_RD,     C_ALWAYS,     ST_RO_WR,     ST_RO_WR};
            ST_RO_WR:     w = '{OP_RO_WR,     C_RO_MORE,    ST_RO_RD,     ST_FINISH};
            ST_FINISH:    w = '{OP_FINISH,    C_ALWAYS,     ST_IDLE,      ST_IDLE};
            default:      w = '{OP_NOP,       C_ALWAYS,     ST_IDLE,      ST_IDLE};
        endcase
        return w;
    endfunction

    upc_t pc_reg;
    upc_t pc_next;
    logic cond_true;

    assign uword_o = ucode_rom(pc_reg);

    always_comb begin
        case (uword_o.cond)
            C_ALWAYS:     cond_true = 1'b1;
            C_LAST_IN:    cond_true = flags_i.last_in;
            C_SIZE_MORE:  cond_true = flags_i.size_more;
            C_RING:       cond_true = flags_i.ring;
            C_MORE_DOWN:  cond_true = flags_i.more_down;
            C_MORE_LEFT:  cond_true = flags_i.more_left;
            C_MORE_UP:    cond_true = flags_i.more_up;
            C_MORE_RIGHT: cond_true = flags_i.more_right;
            C_ROW_LEFT:   cond_true = flags_i.row_left;
            C_ROW_MORE:   cond_true = flags_i.row_more;
            C_COL_LEFT:   cond_true = flags_i.col_left;
            C_COL_MORE:   cond_true = flags_i.col_more;
            C_DECRYPT:    cond_true = flags_i.decrypt;
            C_RO_MORE:    cond_true = flags_i.ro_more;
            default:      cond_true = 1'b0;
        endcase
        if (flags_i.hold) begin
            pc_next = pc_reg;
        end else if (cond_true) begin
            pc_next = uword_o.tgt_t;
        end else begin
            pc_next = uword_o.tgt_f;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- src/srt_dpath.sv -----
module srt_dpath import srt_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  uword_t            uword_i,
    output uflags_t           flags_o,
    input  logic [COLS_W-1:0] cfg_columns_i,
    input  logic              cfg_mode_i,
    input  logic [BYTE_W-1:0] s_in_byte,
    input  logic              s_in_last,
    input  logic              s_valid,
    output logic              s_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_out_last,
    output logic              m_overflow,
    output logic              m_valid,
    input  logic              m_ready
);

    localparam int CNT_W  = $clog2(MAX_CELLS + 1);
    localparam int ADDR_W = $clog2(MAX_CELLS);
    localparam int CELL_W = $clog2(2 * MAX_CELLS);

    logic [BYTE_W-1:0] store_mem [MAX_CELLS];
    logic [BYTE_W-1:0] obuf_mem  [MAX_CELLS];

    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic              ovf_seen_reg, ovf_seen_next;
    logic [CNT_W-1:0]  cols_reg, cols_next;
    logic [CNT_W-1:0]  rows_reg, rows_next;
    logic [CELL_W-1:0] acc_reg, acc_next;
    logic [ADDR_W-1:0] top_reg, top_next;
    logic [ADDR_W-1:0] bot_reg, bot_next;
    logic [ADDR_W-1:0] lft_reg, lft_next;
    logic [ADDR_W-1:0] rgt_reg, rgt_next;
    logic [ADDR_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [CELL_W-1:0] idx_reg, idx_next;
    logic [CELL_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic              ovf_reg, ovf_next;
    logic              hit_reg, hit_next;
    logic [BYTE_W-1:0] store_q_reg;
    logic [BYTE_W-1:0] obuf_q_reg;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic              m_last_reg, m_last_next;
    logic              m_ovf_reg, m_ovf_next;

    logic              accept;
    logic              is_wr;
    logic              enc_out;
    logic              out_req;
    logic              slot_free;
    logic              go;
    logic              out_load;
    logic              store_full;
    logic [CNT_W-1:0]  cols_clamp;
    logic [CELL_W-1:0] n_ext;
    logic [CELL_W-1:0] emit_ext;
    logic [CELL_W-1:0] cols_ext;
    logic [CELL_W-1:0] k_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic              obuf_we;
    logic [BYTE_W-1:0] obuf_wdata;

    assign n_ext      = CELL_W'(byte_count_reg);
    assign emit_ext   = CELL_W'(emit_reg);
    assign cols_ext   = CELL_W'(cols_reg);
    assign k_inc      = k_reg + CELL_W'(1);
    assign store_full = (byte_count_reg == CNT_W'(MAX_CELLS));

    assign s_ready = (uword_i.op == OP_LOAD);
    assign accept  = s_valid && s_ready;

    assign is_wr = (uword_i.op == OP_WR_DOWN) || (uword_i.op == OP_WR_LEFT) ||
                   (uword_i.op == OP_WR_UP)   || (uword_i.op == OP_WR_RIGHT);
    assign enc_out   = !cfg_mode_i && (k_reg < emit_ext);
    assign out_req   = (is_wr && enc_out) || (uword_i.op == OP_RO_WR);
    assign slot_free = !m_valid_reg || m_ready;
    assign go        = !(out_req && !slot_free);
    assign out_load  = out_req && slot_free;

    always_comb begin
        if (cfg_columns_i == '0) begin
            cols_clamp = CNT_W'(1);
        end else if (cfg_columns_i > COLS_W'(MAX_CELLS)) begin
            cols_clamp = CNT_W'(MAX_CELLS);
        end else begin
            cols_clamp = CNT_W'(cfg_columns_i);
        end
    end

    always_comb begin
        flags_o.hold       = !go;
        flags_o.last_in    = accept && s_in_last;
        flags_o.size_more  = (acc_reg + cols_ext) < n_ext;
        flags_o.ring       = (top_reg < bot_reg) && (lft_reg < rgt_reg);
        flags_o.more_down  = (row_reg + ADDR_W'(1)) != bot_reg;
        flags_o.more_left  = col_reg != (lft_reg + ADDR_W'(1));
        flags_o.more_up    = row_reg != (top_reg + ADDR_W'(1));
        flags_o.more_right = (col_reg + ADDR_W'(1)) != rgt_reg;
        flags_o.row_left   = (top_reg == bot_reg) && (lft_reg <= rgt_reg);
        flags_o.row_more   = col_reg != lft_reg;
        flags_o.col_left   = (lft_reg == rgt_reg) && (top_reg < bot_reg);
        flags_o.col_more   = row_reg != bot_reg;
        flags_o.decrypt    = cfg_mode_i;
        flags_o.ro_more    = k_inc != emit_ext;
    end

    always_comb begin
        byte_count_next = byte_count_reg;
        ovf_seen_next   = ovf_seen_reg;
        cols_next       = cols_reg;
        rows_next       = rows_reg;
        acc_next        = acc_reg;
        top_next        = top_reg;
        bot_next        = bot_reg;
        lft_next        = lft_reg;
        rgt_next        = rgt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        emit_next       = emit_reg;
        ovf_next        = ovf_reg;
        hit_next        = hit_reg;
        case (uword_i.op)
            OP_LOAD: begin
                if (accept) begin
                    if (store_full) begin
                        ovf_seen_next = 1'b1;
                    end else begin
                        byte_count_next = byte_count_reg + CNT_W'(1);
                    end
                end
            end
            OP_SIZE_INIT: begin
                cols_next = cols_clamp;
                acc_next  = '0;
                rows_next = '0;
            end
            OP_SIZE_STEP: begin
                acc_next  = acc_reg + cols_ext;
                rows_next = rows_reg + CNT_W'(1);
            end
            OP_RING_INIT: begin
                top_next  = '0;
                bot_next  = ADDR_W'(rows_reg - CNT_W'(1));
                lft_next  = '0;
                rgt_next  = ADDR_W'(cols_reg - CNT_W'(1));
                row_next  = '0;
                col_next  = ADDR_W'(cols_reg - CNT_W'(1));
                idx_next  = cols_ext - CELL_W'(1);
                k_next    = '0;
                emit_next = (acc_reg > CELL_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS)
                                                           : CNT_W'(acc_reg);
                ovf_next  = ovf_seen_reg || (acc_reg > CELL_W'(MAX_CELLS));
            end
            OP_SPIRAL_RD: begin
                hit_next = cfg_mode_i ? (k_reg < n_ext) : (idx_reg < n_ext);
            end
            OP_WR_DOWN: begin
                if (go) begin
                    row_next = row_reg + ADDR_W'(1);
                    idx_next = idx_reg + cols_ext;
                    k_next   = k_inc;
                end
            end
            OP_WR_LEFT: begin
                if (go) begin
                    col_next = col_reg - ADDR_W'(1);
                    idx_next = idx_reg - CELL_W'(1);
                    k_next   = k_inc;
                end
            end
            OP_WR_UP: begin
                if (go) begin
                    row_next = row_reg - ADDR_W'(1);
                    idx_next = idx_reg - cols_ext;
                    k_next   = k_inc;
                end
            end
            OP_WR_RIGHT: begin
                if (go) begin
                    col_next = col_reg + ADDR_W'(1);
                    idx_next = idx_reg + CELL_W'(1);
                    k_next   = k_inc;
                end
            end
            OP_SHRINK: begin
                top_next = top_reg + ADDR_W'(1);
                bot_next = bot_reg - ADDR_W'(1);
                lft_next = lft_reg + ADDR_W'(1);
                rgt_next = rgt_reg - ADDR_W'(1);
                row_next = top_reg + ADDR_W'(1);
                col_next = rgt_reg - ADDR_W'(1);
                idx_next = idx_reg + cols_ext - CELL_W'(1);
            end
            OP_RO_INIT: begin
                k_next = '0;
            end
            OP_RO_WR: begin
                if (go) begin
                    k_next = k_inc;
                end
            end
            OP_FINISH: begin
                byte_count_next = '0;
                ovf_seen_next   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_last_next  = k_inc == emit_ext;
            m_ovf_next   = ovf_reg;
            if (uword_i.op == OP_RO_WR) begin
                m_byte_next = obuf_q_reg;
            end else begin
                m_byte_next = hit_reg ? store_q_reg : PAD_BYTE;
            end
        end
    end

    assign rd_addr    = cfg_mode_i ? k_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign obuf_we    = is_wr && go && cfg_mode_i && (idx_reg < CELL_W'(MAX_CELLS));
    assign obuf_wdata = hit_reg ? store_q_reg : '0;

    always_ff @(posedge aclk) begin
        if (accept && !store_full) begin
            store_mem[byte_count_reg[ADDR_W-1:0]] <= s_in_byte;
        end
        if (uword_i.op == OP_SPIRAL_RD) begin
            store_q_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (obuf_we) begin
            obuf_mem[idx_reg[ADDR_W-1:0]] <= obuf_wdata;
        end
        if (uword_i.op == OP_RO_RD) begin
            obuf_q_reg <= obuf_mem[k_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            ovf_seen_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            ovf_seen_reg   <= ovf_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cols_reg   <= cols_next;
        rows_reg   <= rows_next;
        acc_reg    <= acc_next;
        top_reg    <= top_next;
        bot_reg    <= bot_next;
        lft_reg    <= lft_next;
        rgt_reg    <= rgt_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        emit_reg   <= emit_next;
        ovf_reg    <= ovf_next;
        hit_reg    <= hit_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;
    assign m_overflow = m_ovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CNT_W'(MAX_CELLS))
        else $error("byte count beyond store size");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten before transfer");

    a_load_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (k_reg < emit_ext))
        else $error("result produced past end of run");

    a_size_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        (uword_i.op == OP_RING_INIT) |-> (acc_reg >= n_ext))
        else $error("grid smaller than message");

endmodule

// ----- src/spiral_route_transposition_core.sv -----
// Spiral route transposition of a byte message.
// Input channel (s_valid/s_ready, s_in_byte, s_in_last): one message byte per
// transfer, one per cycle while the block is collecting; s_in_last ends the message.
// Result channel (m_valid/m_ready, m_out_byte, m_out_last, m_overflow): the
// transformed grid, m_out_last on its final byte, m_overflow constant over the run.
// APB registers: 0x0 columns (grid width, 0 taken as 1, clamped to MAX_CELLS),
// 0x4 mode (0 row fill and spiral read, 1 spiral fill and row read).
// After the last byte the block counts the rows of the grid, then walks the spiral
// with a store read and a write step per grid cell and a check and shrink step per
// ring; mode 1 then adds a row-order readout, a buffer read and a write per result.
// A message is not taken while its run is in progress; the next message may
// start while the final result still waits in the output register.
// When the receiver stalls, the walk holds on the output register and resumes.
// Reset returns columns to 4 and mode to 0 and clears the byte count and
// overflow flag; the store keeps no reset value.
module spiral_route_transposition_core import srt_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic [BYTE_W-1:0] s_in_byte,
    input  logic              s_in_last,
    input  logic              s_valid,
    output logic              s_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_out_last,
    output logic              m_overflow,
    output logic              m_valid,
    input  logic              m_ready
);

    logic [COLS_W-1:0] columns_reg, columns_next;
    logic              mode_reg, mode_next;
    logic              cfg_wr;
    uword_t            uword;
    uflags_t           flags;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        columns_next = columns_reg;
        mode_next    = mode_reg;
        if (cfg_wr) begin
            if (paddr[2] == REG_COLUMNS) begin
                columns_next = pwdata[COLS_W-1:0];
            end else begin
                mode_next = pwdata[0];
            end
        end
        if (paddr[2] == REG_MODE) begin
            prdata = APB_DW'(mode_reg);
        end else begin
            prdata = APB_DW'(columns_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= COLUMNS_RST;
            mode_reg    <= MODE_RST;
        end else begin
            columns_reg <= columns_next;
            mode_reg    <= mode_next;
        end
    end

    srt_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags_i (flags),
        .uword_o (uword)
    );

    srt_dpath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .uword_i       (uword),
        .flags_o       (flags),
        .cfg_columns_i (columns_reg),
        .cfg_mode_i    (mode_reg),
        .s_in_byte     (s_in_byte),
        .s_in_last     (s_in_last),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_out_byte    (m_out_byte),
        .m_out_last    (m_out_last),
        .m_overflow    (m_overflow),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule
